### hdl/record_header_parser_core_defines.svh
// Assertion helpers for the record header parser
`ifndef RECORD_HEADER_PARSER_CORE_DEFINES_SVH
`define RECORD_HEADER_PARSER_CORE_DEFINES_SVH

// same-cycle implication
`define RHP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RHP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/rhp_pkg.sv
package rhp_pkg;

  localparam int unsigned ResultDepth = 4;
  localparam int unsigned DepthW      = $clog2(ResultDepth);
  localparam int unsigned CountW      = $clog2(ResultDepth + 1);

  localparam int unsigned InTdataW  = 8;
  localparam int unsigned InTuserW  = 1;
  localparam int unsigned OutTdataW = 208;
  localparam int unsigned OutTuserW = 3;

  localparam int unsigned ContBit    = 7;
  localparam int unsigned LongVarint = 8;
  localparam logic [63:0] TypeRsvdA  = 64'd10;
  localparam logic [63:0] TypeRsvdB  = 64'd11;
  localparam logic [63:0] TypeSmallLimit = 64'd10;
  localparam logic [62:0] VarBias    = 63'd6;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_RECSIZE = 3'd1,
    PH_ROWID   = 3'd2,
    PH_HDRSIZE = 3'd3,
    PH_SERIAL  = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    KIND_RECSIZE = 3'd0,
    KIND_ROWID   = 3'd1,
    KIND_HDRSIZE = 3'd2,
    KIND_SERIAL  = 3'd3,
    KIND_DONE    = 3'd4,
    KIND_ERROR   = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ERR_PAGE_END = 2'd0,
    ERR_RESERVED = 2'd1,
    ERR_OVERRUN  = 2'd2,
    ERR_HDR_SHORT = 2'd3
  } err_e;

  typedef struct packed {
    kind_e       kind;
    logic [63:0] value;
    logic [62:0] column_size;
    logic [7:0]  column_count;
    logic [63:0] total_size;
    logic [4:0]  record_start_offset;
    err_e        error_code;
    logic        last;
  } result_t;

  typedef struct packed {
    logic       en;
    logic [7:0] data_byte;
    logic       cell_start;
    logic       page_end;
  } step_t;

  typedef struct packed {
    logic              room;
    logic [CountW-1:0] count;
  } queue_stat_t;

  function automatic logic [3:0] small_type_size(input logic [3:0] t);
    logic [3:0] s;
    unique case (t)
      4'd1:    s = 4'd1;
      4'd2:    s = 4'd2;
      4'd3:    s = 4'd3;
      4'd4:    s = 4'd4;
      4'd5:    s = 4'd6;
      4'd6:    s = 4'd8;
      4'd7:    s = 4'd8;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

  function automatic result_t make_result(input kind_e k, input logic [63:0] v,
                                          input logic [62:0] cs, input logic [7:0] cc,
                                          input logic [63:0] ts, input logic [4:0] pf,
                                          input err_e e);
    result_t r;
    r.kind                = k;
    r.value               = v;
    r.column_size         = cs;
    r.column_count        = cc;
    r.total_size          = ts;
    r.record_start_offset = pf;
    r.error_code          = e;
    r.last                = 1'b0;
    return r;
  endfunction

endpackage

### hdl/rhp_parser.sv
module rhp_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rhp_pkg::step_t   step_i,
  output logic [1:0]       n_res_o,
  output rhp_pkg::result_t res0_o,
  output rhp_pkg::result_t res1_o
);

  rhp_pkg::phase_e phase_q, phase_d;
  logic [63:0] acc_q, acc_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [63:0] hbl_q, hbl_d;
  logic [63:0] sum_q, sum_d;
  logic [7:0]  ccnt_q, ccnt_d;
  logic [4:0]  pfx_q, pfx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= rhp_pkg::PH_IDLE;
      acc_q   <= '0;
      cnt_q   <= '0;
      hbl_q   <= '0;
      sum_q   <= '0;
      ccnt_q  <= '0;
      pfx_q   <= '0;
    end else if (step_i.en) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      hbl_q   <= hbl_d;
      sum_q   <= sum_d;
      ccnt_q  <= ccnt_d;
      pfx_q   <= pfx_d;
    end
  end

  rhp_pkg::phase_e phase_e;
  logic [63:0] acc_e, hbl_e, sum_e, v;
  logic [3:0]  cnt_e, used;
  logic [7:0]  ccnt_e;
  logic [4:0]  pfx_e;
  logic        complete;
  logic [62:0] csize;
  logic [1:0]  n;
  rhp_pkg::result_t r0, r1;

  always_comb begin
    // a cell start restarts the parse before this byte is taken
    phase_e = step_i.cell_start ? rhp_pkg::PH_RECSIZE : phase_q;
    acc_e   = step_i.cell_start ? '0 : acc_q;
    cnt_e   = step_i.cell_start ? '0 : cnt_q;
    hbl_e   = step_i.cell_start ? '0 : hbl_q;
    sum_e   = step_i.cell_start ? '0 : sum_q;
    ccnt_e  = step_i.cell_start ? '0 : ccnt_q;
    pfx_e   = step_i.cell_start ? '0 : pfx_q;

    if (cnt_e < 4'(rhp_pkg::LongVarint)) begin
      v        = {acc_e[56:0], step_i.data_byte[6:0]};
      complete = !step_i.data_byte[rhp_pkg::ContBit];
    end else begin
      v        = {acc_e[55:0], step_i.data_byte};
      complete = 1'b1;
    end
    used = cnt_e + 4'd1;

    // serial types 12 and up: (t >> 1) - 6 for either parity
    if (v < rhp_pkg::TypeSmallLimit) begin
      csize = {59'd0, rhp_pkg::small_type_size(v[3:0])};
    end else begin
      csize = v[63:1] - rhp_pkg::VarBias;
    end

    phase_d = phase_e;
    acc_d   = acc_e;
    cnt_d   = cnt_e;
    hbl_d   = hbl_e;
    sum_d   = sum_e;
    ccnt_d  = ccnt_e;
    pfx_d   = pfx_e;
    n       = 2'd0;
    r0      = '0;
    r1      = '0;

    if (phase_e != rhp_pkg::PH_IDLE) begin
      if (!complete) begin
        acc_d = v;
        cnt_d = used;
        if (step_i.page_end) begin
          r0      = rhp_pkg::make_result(rhp_pkg::KIND_ERROR, '0, '0, ccnt_e, sum_e,
                                         pfx_e, rhp_pkg::ERR_PAGE_END);
          n       = 2'd1;
          phase_d = rhp_pkg::PH_IDLE;
        end
      end else begin
        acc_d = '0;
        cnt_d = '0;
        n     = 2'd1;
        unique case (phase_e)
          rhp_pkg::PH_RECSIZE: begin
            pfx_d   = {1'b0, used};
            r0      = rhp_pkg::make_result(rhp_pkg::KIND_RECSIZE, v, '0, ccnt_e, sum_e,
                                           pfx_d, rhp_pkg::ERR_PAGE_END);
            phase_d = rhp_pkg::PH_ROWID;
          end
          rhp_pkg::PH_ROWID: begin
            pfx_d   = pfx_e + {1'b0, used};
            r0      = rhp_pkg::make_result(rhp_pkg::KIND_ROWID, v, '0, ccnt_e, sum_e,
                                           pfx_d, rhp_pkg::ERR_PAGE_END);
            phase_d = rhp_pkg::PH_HDRSIZE;
          end
          rhp_pkg::PH_HDRSIZE: begin
            r0 = rhp_pkg::make_result(rhp_pkg::KIND_HDRSIZE, v, '0, ccnt_e, sum_e,
                                      pfx_e, rhp_pkg::ERR_PAGE_END);
            if (v < {60'd0, used}) begin
              r1      = rhp_pkg::make_result(rhp_pkg::KIND_ERROR, '0, '0, ccnt_e, sum_e,
                                             pfx_e, rhp_pkg::ERR_HDR_SHORT);
              n       = 2'd2;
              phase_d = rhp_pkg::PH_IDLE;
            end else begin
              hbl_d = v - {60'd0, used};
              if (hbl_d == '0) begin
                r1      = rhp_pkg::make_result(rhp_pkg::KIND_DONE, '0, '0, ccnt_e, sum_e,
                                               pfx_e, rhp_pkg::ERR_PAGE_END);
                n       = 2'd2;
                phase_d = rhp_pkg::PH_IDLE;
              end else begin
                phase_d = rhp_pkg::PH_SERIAL;
              end
            end
          end
          rhp_pkg::PH_SERIAL: begin
            if (v == rhp_pkg::TypeRsvdA || v == rhp_pkg::TypeRsvdB) begin
              r0      = rhp_pkg::make_result(rhp_pkg::KIND_ERROR, '0, '0, ccnt_e, sum_e,
                                             pfx_e, rhp_pkg::ERR_RESERVED);
              phase_d = rhp_pkg::PH_IDLE;
            end else begin
              sum_d  = sum_e + {1'b0, csize};
              ccnt_d = ccnt_e + 8'd1;
              r0     = rhp_pkg::make_result(rhp_pkg::KIND_SERIAL, v, csize, ccnt_d, sum_d,
                                            pfx_e, rhp_pkg::ERR_PAGE_END);
              if ({60'd0, used} > hbl_e) begin
                r1      = rhp_pkg::make_result(rhp_pkg::KIND_ERROR, '0, '0, ccnt_d, sum_d,
                                               pfx_e, rhp_pkg::ERR_OVERRUN);
                n       = 2'd2;
                phase_d = rhp_pkg::PH_IDLE;
              end else begin
                hbl_d = hbl_e - {60'd0, used};
                if (hbl_d == '0) begin
                  r1      = rhp_pkg::make_result(rhp_pkg::KIND_DONE, '0, '0, ccnt_d,
                                                 sum_d, pfx_e, rhp_pkg::ERR_PAGE_END);
                  n       = 2'd2;
                  phase_d = rhp_pkg::PH_IDLE;
                end
              end
            end
          end
          default: phase_d = rhp_pkg::PH_IDLE;
        endcase
        if (step_i.page_end && phase_d != rhp_pkg::PH_IDLE) begin
          r1      = rhp_pkg::make_result(rhp_pkg::KIND_ERROR, '0, '0, ccnt_d, sum_d,
                                         pfx_d, rhp_pkg::ERR_PAGE_END);
          n       = 2'd2;
          phase_d = rhp_pkg::PH_IDLE;
        end
      end
    end

    if (n == 2'd2) begin
      r1.last = 1'b1;
    end else begin
      r0.last = 1'b1;
    end
  end

  assign n_res_o = n;
  assign res0_o  = r0;
  assign res1_o  = r1;

endmodule

### hdl/rhp_queue.sv
module rhp_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [1:0]           push_n_i,
  input  rhp_pkg::result_t     push0_i,
  input  rhp_pkg::result_t     push1_i,
  input  logic                 pop_i,
  output logic                 valid_o,
  output rhp_pkg::result_t     head_o,
  output rhp_pkg::queue_stat_t stat_o
);

  localparam int unsigned Depth  = rhp_pkg::ResultDepth;
  localparam int unsigned PtrW   = rhp_pkg::DepthW;
  localparam int unsigned CountW = rhp_pkg::CountW;

  rhp_pkg::result_t  mem_q [Depth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              do_pop;

  assign do_pop = pop_i && (cnt_q != '0);

  always_comb begin
    wr_d  = wr_q + PtrW'(push_n_i);
    rd_d  = rd_q + PtrW'(do_pop);
    cnt_d = cnt_q + CountW'(push_n_i) - CountW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_q] <= push0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_q + PtrW'(1)] <= push1_i;
    end
  end

  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_q];
  assign stat_o  = '{room: (cnt_q <= CountW'(Depth - 2)), count: cnt_q};

endmodule

### hdl/record_header_parser_core.sv
// Path: input register, combinational parser, then the result queue that drives the output.
// Throughput: one byte per cycle while the result queue has room for two more results;
// a byte that gives two results pushes both into the 4-entry queue at once.
// Input side stalls only when the result queue cannot take two more results.
// Reset: asynchronous, active low; parser goes idle with all its state zero, queue empty.
`include "record_header_parser_core_defines.svh"

module record_header_parser_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [rhp_pkg::InTdataW-1:0]      s_axis_tdata,   // data_byte
  input  logic [rhp_pkg::InTuserW-1:0]      s_axis_tuser,   // cell_start
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // value, column_size, column_count, total_size, record_start_offset, error_code, pad
  output logic [rhp_pkg::OutTdataW-1:0]     m_axis_tdata,
  output logic [rhp_pkg::OutTuserW-1:0]     m_axis_tuser,   // kind
  output logic                              m_axis_tlast
);

  logic                 in_vld_q;
  logic [7:0]           in_byte_q;
  logic                 in_start_q, in_pend_q;
  logic                 fire;
  rhp_pkg::step_t       step;
  rhp_pkg::queue_stat_t qstat;
  logic [1:0]           n_res;
  rhp_pkg::result_t     res0, res1, head;
  logic                 q_valid;

  assign fire          = in_vld_q && qstat.room;
  assign s_axis_tready = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q  <= s_axis_tdata;
      in_start_q <= s_axis_tuser[0];
      in_pend_q  <= s_axis_tlast;
    end
  end

  always_comb begin
    step.en         = fire;
    step.data_byte  = in_byte_q;
    step.cell_start = in_start_q;
    step.page_end   = in_pend_q;
  end

  rhp_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .n_res_o (n_res),
    .res0_o  (res0),
    .res1_o  (res1)
  );

  rhp_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (fire ? n_res : 2'd0),
    .push0_i  (res0),
    .push1_i  (res1),
    .pop_i    (m_axis_tready),
    .valid_o  (q_valid),
    .head_o   (head),
    .stat_o   (qstat)
  );

  assign m_axis_tvalid = q_valid;
  assign m_axis_tdata  = {2'b00, head.error_code, head.record_start_offset,
                          head.total_size, head.column_count, head.column_size,
                          head.value};
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = head.last;

  `RHP_ASSERT_NOW(a_queue_bound, 1'b1, qstat.count <= rhp_pkg::CountW'(rhp_pkg::ResultDepth), "result queue overfilled")
  `RHP_ASSERT_NOW(a_valid_tracks_count, 1'b1, m_axis_tvalid == (qstat.count != '0), "output valid disagrees with queue fill")
  `RHP_ASSERT_NEXT(a_stall_holds, in_vld_q && !fire, in_vld_q && $stable(in_byte_q), "stalled input byte lost")
  `RHP_ASSERT_NEXT(a_push_grows, fire && n_res != 2'd0 && !(m_axis_tvalid && m_axis_tready), qstat.count != '0, "pushed result missing from queue")

endmodule
